FILE: src/ssa_pkg.sv
package ssa_pkg;
  localparam int MaxElemsDefault = 32;
  localparam logic [1:0] FUNC_ADD_A  = 2'd0;
  localparam logic [1:0] FUNC_ADD_B  = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] OP_UNION = 2'd0;
  localparam logic [1:0] OP_INTER = 2'd1;
  localparam logic [1:0] OP_DIFF  = 2'd2;
  localparam logic [1:0] OP_XOR   = 2'd3;

  // Control that every cell of a set chain sees in the same cycle.
  typedef struct packed {
    logic ins;      // insert the broadcast key this cycle
    logic shift;    // pop the head: every cell takes its right neighbor
    logic clear;    // drop all contents
  } ssa_ctl_t;
endpackage

FILE: src/sorted_set_algebra.sv
// Sorted set algebra over two sets of signed 64-bit integers.
// Input beats are taken when start is high and busy is low. func selects
// add-to-A, add-to-B or finish; finish carries set_op (union,
// intersection, A minus B, symmetric difference). Code 3 is ignored.
// Each set is a row of cells kept sorted: an add compares the key against
// every cell in parallel and the cells at and after the insert point move
// right by one; after each add beat busy stays high in a hold state, so
// the next beat waits. Duplicates collapse; a new key on a full set is
// dropped and flags overflow on every result beat of the next finish.
// A finish merges the two chain heads: each cycle the heads are compared
// and one or both chains shift left, emitting at most one result beat on
// out_valid. The merge ends once both chains are empty;
// an empty result gives a single beat with out_is_empty and out_is_last.
// The receiver cannot stall: each result beat is shown for one cycle.
// Reset (synchronous, rst_n low) empties both sets and clears overflow;
// finishing does the same, and busy is low while the last result beat shows.
module sorted_set_algebra #(
  parameter int MAX_ELEMS = ssa_pkg::MaxElemsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [63:0] in_value,
  input  logic [1:0]         in_set_op,
  output logic               out_valid,
  output logic signed [63:0] out_element,
  output logic               out_is_empty,
  output logic               out_is_last,
  output logic               out_overflow
);
  import ssa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HOLD = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [1:0]  op_r;
  logic        drop_r, drop_nxt;
  logic        any_r;            // an element was already taken for the result
  logic [63:0] key;
  ssa_ctl_t    ctl_a, ctl_b;
  logic        dup_a, dup_b, full_a, full_b, hv_a, hv_b;
  logic [63:0] hk_a, hk_b;
  logic        acc;

  assign acc  = start && !busy;
  assign busy = (st_r != ST_IDLE);
  // Order key: sign bit flipped so unsigned compare orders signed values.
  assign key  = {~in_value[63], in_value[62:0]};

  ssa_chain #(.MAX_ELEMS(MAX_ELEMS)) u_a (.clk(clk), .rst_n(rst_n), .ctl(ctl_a),
    .key(key), .dup(dup_a), .full(full_a), .head_vld(hv_a), .head_key(hk_a));
  ssa_chain #(.MAX_ELEMS(MAX_ELEMS)) u_b (.clk(clk), .rst_n(rst_n), .ctl(ctl_b),
    .key(key), .dup(dup_b), .full(full_b), .head_vld(hv_b), .head_key(hk_b));

  logic take_a, take_b, a_lt, b_lt, tk, done;
  logic [63:0] pick;

  always_comb begin
    a_lt = hv_a && (!hv_b || hk_a < hk_b);
    b_lt = hv_b && (!hv_a || hk_b < hk_a);
    take_a = a_lt || (hv_a && hv_b && !b_lt);
    take_b = b_lt || (hv_a && hv_b && !a_lt);
    pick = take_a ? hk_a : hk_b;
    if (a_lt)      tk = (op_r == OP_UNION) || (op_r == OP_DIFF) || (op_r == OP_XOR);
    else if (b_lt) tk = (op_r == OP_UNION) || (op_r == OP_XOR);
    else           tk = (op_r == OP_UNION) || (op_r == OP_INTER);
    tk = tk && (hv_a || hv_b);
    done = !hv_a && !hv_b;
  end

  // Output staging: a taken element is held until the next one is taken or
  // the merge turns out to be over, so that is_last can be marked.
  logic        pend_r, pend_nxt;
  logic [63:0] pend_key_r, pend_key_nxt;
  logic        any_nxt;
  logic        ov_nxt, oe_nxt, ol_nxt;
  logic [63:0] ok_nxt;

  always_comb begin
    st_nxt = st_r;
    drop_nxt = drop_r;
    ctl_a = '0;
    ctl_b = '0;
    pend_nxt = pend_r;
    pend_key_nxt = pend_key_r;
    any_nxt = any_r;
    ov_nxt = 1'b0; oe_nxt = 1'b0; ol_nxt = 1'b0; ok_nxt = pend_key_r;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_func)
            FUNC_ADD_A: begin
              ctl_a.ins = 1'b1;
              if (!dup_a && full_a) drop_nxt = 1'b1;
              st_nxt = ST_HOLD;
            end
            FUNC_ADD_B: begin
              ctl_b.ins = 1'b1;
              if (!dup_b && full_b) drop_nxt = 1'b1;
              st_nxt = ST_HOLD;
            end
            FUNC_FINISH: begin
              st_nxt = ST_MERGE;
              pend_nxt = 1'b0;
              any_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_HOLD: st_nxt = ST_IDLE;
      ST_MERGE: begin
        if (done) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          oe_nxt = !pend_r;
          ok_nxt = pend_r ? pend_key_r : 64'h8000_0000_0000_0000;
          st_nxt = ST_IDLE;
          drop_nxt = 1'b0;
          ctl_a.clear = 1'b1;
          ctl_b.clear = 1'b1;
        end else begin
          ctl_a.shift = take_a;
          ctl_b.shift = take_b;
          if (tk) begin
            ov_nxt = pend_r;
            pend_nxt = 1'b1;
            pend_key_nxt = pick;
            any_nxt = 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic        ov_r, oe_r, ol_r, of_r;
  logic [63:0] ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; drop_r <= 1'b0; pend_r <= 1'b0; any_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; drop_r <= drop_nxt; pend_r <= pend_nxt; any_r <= any_nxt;
      ov_r <= ov_nxt;
    end
    if (acc) op_r <= in_set_op;
    pend_key_r <= pend_key_nxt;
    oe_r <= oe_nxt; ol_r <= ol_nxt; ok_r <= ok_nxt; of_r <= drop_r;
  end

  assign out_valid    = ov_r;
  assign out_element  = {~ok_r[63], ok_r[62:0]};
  assign out_is_empty = oe_r;
  assign out_is_last  = ol_r;
  assign out_overflow = of_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MERGE && done) |=> (out_valid && out_is_last && !busy))
    else $error("merge end without last beat");
  a_empty_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> out_is_last)
    else $error("empty beat not last");
  a_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MERGE && done && any_r) |=> !out_is_empty)
    else $error("empty flagged after elements");
endmodule

FILE: src/ssa_cell.sv
module ssa_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ssa_pkg::ssa_ctl_t ctl,
  input  logic [63:0]       key,
  input  logic              left_vld,
  input  logic              left_lt,
  input  logic [63:0]       left_key,
  input  logic              right_vld,
  input  logic [63:0]       right_key,
  output logic              vld,
  output logic              lt,
  output logic              eq,
  output logic [63:0]       val
);
  import ssa_pkg::*;
  logic        vld_r, vld_nxt;
  logic [63:0] val_r, val_nxt;

  // A cell's stored key is below the new key; an empty cell never is.
  assign lt  = vld_r && (val_r < key);
  assign eq  = vld_r && (val_r == key);
  assign vld = vld_r;
  assign val = val_r;

  // On an insert, the first cell not below the key takes the key and every
  // valid cell after it moves one place right. Empty cells further on stay
  // empty.
  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (ctl.clear) begin
      vld_nxt = 1'b0;
    end else if (ctl.shift) begin
      vld_nxt = right_vld;
      val_nxt = right_key;
    end else if (ctl.ins && !lt) begin
      if (left_vld && !left_lt) begin
        vld_nxt = left_vld;
        val_nxt = left_key;
      end else if (left_lt) begin
        vld_nxt = 1'b1;
        val_nxt = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
    val_r <= val_nxt;
  end
endmodule

FILE: src/ssa_chain.sv
module ssa_chain #(
  parameter int MAX_ELEMS = ssa_pkg::MaxElemsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ssa_pkg::ssa_ctl_t ctl,
  input  logic [63:0]       key,
  output logic              dup,
  output logic              full,
  output logic              head_vld,
  output logic [63:0]       head_key
);
  import ssa_pkg::*;
  logic [MAX_ELEMS-1:0] vld, lt, eq;
  logic [63:0] val [MAX_ELEMS];
  ssa_ctl_t cctl;

  // Insertion on a full chain or of a present key is suppressed.
  assign dup  = |eq;
  assign full = vld[MAX_ELEMS-1];
  always_comb begin
    cctl = ctl;
    cctl.ins = ctl.ins && !dup && !full;
  end

  for (genvar g = 0; g < MAX_ELEMS; g++) begin : g_cell
    logic lv, ll, rv;
    logic [63:0] lk, rk;
    if (g == 0) begin : g_first
      // The head cell sees a left neighbor that is below every key.
      assign lv = 1'b0; assign ll = 1'b1; assign lk = '0;
    end else begin : g_mid
      assign lv = vld[g-1]; assign ll = lt[g-1]; assign lk = val[g-1];
    end
    if (g == MAX_ELEMS-1) begin : g_last
      assign rv = 1'b0; assign rk = '0;
    end else begin : g_nlast
      assign rv = vld[g+1]; assign rk = val[g+1];
    end
    ssa_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(cctl), .key(key),
      .left_vld(lv), .left_lt(ll), .left_key(lk),
      .right_vld(rv), .right_key(rk),
      .vld(vld[g]), .lt(lt[g]), .eq(eq[g]), .val(val[g])
    );
  end

  assign head_vld = vld[0];
  assign head_key = val[0];

  // Valid cells always form a prefix of the chain.
  for (genvar g = 1; g < MAX_ELEMS; g++) begin : g_chk
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
      vld[g] |-> vld[g-1]) else $error("chain hole");
  end
endmodule
